FILE: design/dfs_topological_sort_unit_macros.svh
// assertion macros for the dfs topological sort unit
// used by the top level only, no other dependencies
`ifndef DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH
`ifndef SYNTH
`define DFS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`define DFS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define DFS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define DFS_ASSERT_NEVER(label, clk, rst_n, cond)
`define DFS_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define DFS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: design/dfs_pkg.sv
// shared types, codes and defaults of the dfs topological sort unit
// no dependencies
package dfs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 2048;
  localparam logic [6:0] VCNT_RESET = 7'd64;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_SORT = 1'b1;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BADV  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_CYCLE = 3'd3;
  localparam logic [2:0] ST_INERR = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [6:0] edge_from;
    logic [6:0] edge_to;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] vertex;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic accept_in;
    logic start_root;
    logic next_root;
    logic scan_read;
    logic push_tgt;
    logic finish;
    logic pop_load;
    logic emit_read;
    logic emit_load;
    logic cycle_load;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic in_sort;
    logic in_err;
    logic root_done;
    logic root_visited;
    logic pos_zero;
    logic hit;
    logic tgt_white;
    logic tgt_gray;
    logic depth_one;
    logic emit_last;
  } stat_t;

endpackage

FILE: design/dfs_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dfs_ctrl.sv
// sequencer of the dfs topological sort unit
// depends on dfs_pkg for command and status structs
module dfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dfs_pkg::stat_t stat,
  output dfs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ROOT    = 3'd1;
  localparam logic [2:0] S_SCANRD  = 3'd2;
  localparam logic [2:0] S_SCANCHK = 3'd3;
  localparam logic [2:0] S_POPWAIT = 3'd4;
  localparam logic [2:0] S_EMITRD  = 3'd5;
  localparam logic [2:0] S_EMITLD  = 3'd6;
  localparam logic [2:0] S_CYCLE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = !((state_r == S_IDLE) && stat.load_ok);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept_in = 1'b1;
          if (stat.in_sort && !stat.in_err) state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat.root_done) begin
          state_nxt = S_EMITRD;
        end else if (stat.root_visited) begin
          cmd.next_root = 1'b1;
        end else begin
          cmd.start_root = 1'b1;
          state_nxt = S_SCANRD;
        end
      end
      S_SCANRD: begin
        if (stat.pos_zero) begin
          cmd.finish = 1'b1;
          state_nxt = stat.depth_one ? S_ROOT : S_POPWAIT;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt = S_SCANCHK;
        end
      end
      S_SCANCHK: begin
        state_nxt = S_SCANRD;
        if (stat.hit && stat.tgt_white) cmd.push_tgt = 1'b1;
        else if (stat.hit && stat.tgt_gray) state_nxt = S_CYCLE;
      end
      S_POPWAIT: begin
        cmd.pop_load = 1'b1;
        state_nxt = S_SCANRD;
      end
      S_EMITRD: begin
        cmd.emit_read = 1'b1;
        state_nxt = S_EMITLD;
      end
      S_EMITLD: begin
        if (stat.load_ok) begin
          cmd.emit_load = 1'b1;
          state_nxt = stat.emit_last ? S_IDLE : S_EMITRD;
        end
      end
      S_CYCLE: begin
        if (stat.load_ok) begin
          cmd.cycle_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/dfs_dp.sv
// datapath of the dfs topological sort unit: edge store, marks, walk stack,
// finish list and output register; depends on dfs_pkg and dfs_ram
module dfs_dp #(
  parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = dfs_pkg::MAX_EDGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dfs_pkg::in_word_t   in_word,
  input  logic                out_stall,
  output logic                out_valid,
  output dfs_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  dfs_pkg::cmd_t       cmd,
  output dfs_pkg::stat_t      stat
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);

  logic [6:0]              vc_r;
  logic [CW-1:0]           n_c;
  logic [EW-1:0]           ecnt_r;
  logic                    err_r;
  logic [MAX_VERTICES-1:0] gray_r, black_r;
  logic [CW-1:0]           root_r, depth_r, fcnt_r, k_r;
  logic [VW-1:0]           top_node_r;
  logic [EW-1:0]           top_pos_r;
  logic                    out_valid_r;
  dfs_pkg::out_word_t      out_word_r;

  logic                    load_ok;
  logic                    bad_v, full, add_ok;
  logic [2*VW-1:0]         edge_rd;
  logic [VW-1:0]           e_src, e_tgt;
  logic [VW+EW-1:0]        stk_rd;
  logic [VW-1:0]           fin_rd;
  logic                    is_add, is_sort;

  // effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vc_r == 7'd0) n_c = CW'(1);
    else if (32'(vc_r) > MAX_VERTICES) n_c = CW'(MAX_VERTICES);
    else n_c = CW'(vc_r);
  end

  assign load_ok = !out_valid_r || !out_stall;
  assign is_add  = cmd.accept_in && (in_word.opcode == dfs_pkg::OP_ADD);
  assign is_sort = cmd.accept_in && (in_word.opcode == dfs_pkg::OP_SORT);

  assign bad_v = (in_word.edge_from == 7'd0) || (in_word.edge_from > 7'(n_c)) ||
                 (in_word.edge_to == 7'd0) || (in_word.edge_to > 7'(n_c));
  assign full   = ecnt_r >= EW'(MAX_EDGES);
  assign add_ok = is_add && !bad_v && !full;

  dfs_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES), .AW(EA)) u_edge_ram (
    .clk   (clk),
    .we    (add_ok),
    .waddr (ecnt_r[EA-1:0]),
    .wdata ({VW'(7'(in_word.edge_from - 7'd1)), VW'(7'(in_word.edge_to - 7'd1))}),
    .re    (cmd.scan_read),
    .raddr (EA'(top_pos_r - EW'(1))),
    .rdata (edge_rd)
  );

  dfs_ram #(.WIDTH(VW+EW), .DEPTH(MAX_VERTICES), .AW(VW)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push_tgt),
    .waddr (VW'(depth_r - CW'(1))),
    .wdata ({top_node_r, top_pos_r}),
    .re    (cmd.finish),
    .raddr (VW'(depth_r - CW'(2))),
    .rdata (stk_rd)
  );

  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(VW)) u_fin_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (VW'(fcnt_r)),
    .wdata (top_node_r),
    .re    (cmd.emit_read),
    .raddr (VW'(n_c - CW'(1) - k_r)),
    .rdata (fin_rd)
  );

  assign e_src = edge_rd[2*VW-1:VW];
  assign e_tgt = edge_rd[VW-1:0];

  always_comb begin
    stat              = '0;
    stat.load_ok      = load_ok;
    stat.in_sort      = (in_word.opcode == dfs_pkg::OP_SORT);
    stat.in_err       = err_r;
    stat.root_done    = (root_r == n_c);
    stat.root_visited = black_r[VW'(root_r)];
    stat.pos_zero     = (top_pos_r == '0);
    stat.hit          = (e_src == top_node_r) && (CW'(e_src) < n_c) && (CW'(e_tgt) < n_c);
    stat.tgt_gray     = gray_r[e_tgt];
    stat.tgt_white    = !gray_r[e_tgt] && !black_r[e_tgt];
    stat.depth_one    = (depth_r == CW'(1));
    stat.emit_last    = (k_r == n_c - CW'(1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= dfs_pkg::VCNT_RESET;
      ecnt_r      <= '0;
      err_r       <= 1'b0;
      gray_r      <= '0;
      black_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) vc_r <= cfg_wdata;
      if (add_ok) ecnt_r <= ecnt_r + EW'(1);
      if (is_add && !add_ok) err_r <= 1'b1;
      if (is_sort) begin
        gray_r  <= '0;
        black_r <= '0;
      end
      if (cmd.start_root) gray_r[VW'(root_r)] <= 1'b1;
      if (cmd.push_tgt) gray_r[e_tgt] <= 1'b1;
      if (cmd.finish) begin
        gray_r[top_node_r]  <= 1'b0;
        black_r[top_node_r] <= 1'b1;
      end
      // every sort leaves the store and error flag cleared
      if ((is_sort && err_r) || cmd.cycle_load || (cmd.emit_load && stat.emit_last)) begin
        ecnt_r <= '0;
        err_r  <= 1'b0;
      end
      if (is_add || (is_sort && err_r) || cmd.cycle_load || cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (is_sort) begin
      root_r <= '0;
      fcnt_r <= '0;
      k_r    <= '0;
    end
    if (cmd.next_root) root_r <= root_r + CW'(1);
    if (cmd.start_root) begin
      root_r     <= root_r + CW'(1);
      top_node_r <= VW'(root_r);
      top_pos_r  <= ecnt_r;
      depth_r    <= CW'(1);
    end
    if (cmd.scan_read) top_pos_r <= top_pos_r - EW'(1);
    if (cmd.push_tgt) begin
      top_node_r <= e_tgt;
      top_pos_r  <= ecnt_r;
      depth_r    <= depth_r + CW'(1);
    end
    if (cmd.finish) begin
      fcnt_r  <= fcnt_r + CW'(1);
      depth_r <= depth_r - CW'(1);
    end
    if (cmd.pop_load) {top_node_r, top_pos_r} <= stk_rd;
    if (cmd.emit_load) k_r <= k_r + CW'(1);
  end

  // output word
  always_ff @(posedge clk) begin
    if (is_add) begin
      out_word_r.status <= bad_v ? dfs_pkg::ST_BADV : (full ? dfs_pkg::ST_FULL : dfs_pkg::ST_OK);
      out_word_r.vertex <= 7'd0;
      out_word_r.last   <= 1'b1;
    end else if (is_sort && err_r) begin
      out_word_r.status <= dfs_pkg::ST_INERR;
      out_word_r.vertex <= 7'd0;
      out_word_r.last   <= 1'b1;
    end else if (cmd.cycle_load) begin
      out_word_r.status <= dfs_pkg::ST_CYCLE;
      out_word_r.vertex <= 7'd0;
      out_word_r.last   <= 1'b1;
    end else if (cmd.emit_load) begin
      out_word_r.status <= dfs_pkg::ST_OK;
      out_word_r.vertex <= 7'(fin_rd) + 7'd1;
      out_word_r.last   <= stat.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/dfs_topological_sort_unit.sv
// top level of the dfs topological sort unit
// depends on dfs_pkg, dfs_ctrl, dfs_dp and the assertion macro header
//
// usage: an input word with opcode add stores one directed edge (1-based
// endpoints) and returns one word {status, 0, last=1}. an input word with
// opcode sort walks the graph depth first from vertex 1 upward, newest edge
// first, and returns the vertices in topological order (last on the final
// one), or one status word for a cycle or for an earlier rejected edge.
// every sort empties the edge store. cfg_we/cfg_wdata set the vertex count;
// write it only while the unit is idle.
// sequence: an add word is answered in the cycle after acceptance, and the
// next word can be taken once the output register frees. a sort tries each
// root in turn, scans the edge list once per stack frame (a frame rescans
// the whole list, one edge at a time through the single read port of the
// edge ram), finishes each vertex with a pop for each non-root, then emits
// the vertices in order. one word is in work at a time.
// reset: synchronous, clears edges, error flag and marks, vertex count 64.
// out_stall holds the output register; the emit and cycle report steps and the input side wait on it.
module dfs_topological_sort_unit #(
  parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = dfs_pkg::MAX_EDGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dfs_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output dfs_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  `include "dfs_topological_sort_unit_macros.svh"

  dfs_pkg::cmd_t  cmd;
  dfs_pkg::stat_t stat;

  // sequencer
  dfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and output register
  dfs_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // an order word always carries ok status
  `DFS_ASSERT_IMPL(a_vertex_ok, clk, rst_n, out_valid && (out_word.vertex != 7'd0), out_word.status == dfs_pkg::ST_OK)
  // any status other than ok ends the item
  `DFS_ASSERT_IMPL(a_err_last, clk, rst_n, out_valid && (out_word.status != dfs_pkg::ST_OK), out_word.last)
  // an add edge word is answered in the next cycle
  `DFS_ASSERT_NEXT(a_add_ack, clk, rst_n, in_valid && !in_stall && (in_word.opcode == dfs_pkg::OP_ADD), out_valid && out_word.last)

endmodule
